>>> hdl/kwch_pkg.sv
// Shared constants, types and codes for the kernel weighted color histogram.
package kwch_pkg;

  // Field and store widths
  localparam int HALF_W       = 7;
  localparam int CHAN_W       = 8;
  localparam int OFFSET_W     = 7;
  localparam int SELECT_W     = 9;
  localparam int STORE_W      = 30;
  localparam int WEIGHT_W     = 16;
  localparam int FRACTION_W   = 17;
  localparam int SQ_W         = 2 * HALF_W;
  localparam int RADIUS_W     = SQ_W + 1;

  // Defaults and limits
  localparam int BIN_COUNT_DEFAULT = 512;
  localparam int MAX_HALF_SIZE     = 64;
  localparam int RESET_HALF        = 16;

  // Divider produces this many quotient bits, for weight and read fraction
  localparam int QUOT_BITS = 16;
  localparam int QCNT_W    = $clog2(QUOT_BITS + 1);

  localparam logic [STORE_W-1:0]    STORE_MAX    = {STORE_W{1'b1}};
  localparam logic [FRACTION_W-1:0] FRACTION_ONE = FRACTION_W'(1) << QUOT_BITS;

  // Commands
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HALF_WIDTH  = 2'd0,
    REG_HALF_HEIGHT = 2'd1,
    REG_SPARE_2     = 2'd2,
    REG_SPARE_3     = 2'd3
  } reg_index_t;

  // Control states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ACC_KERNEL,
    ST_ACC_DIV,
    ST_ACC_WRITE,
    ST_READ_FETCH,
    ST_READ_DIV
  } state_t;

  // Kernel stage result: radius test and divider operands
  typedef struct packed {
    logic                in_radius;
    logic [RADIUS_W-1:0] numer;
    logic [RADIUS_W-1:0] radius_sq;
  } kern_res_t;

  // Saturating add of a weight onto a stored count
  function automatic logic [STORE_W-1:0] sat_add(input logic [STORE_W-1:0] acc,
                                                 input logic [WEIGHT_W-1:0] w);
    logic [STORE_W:0] sum;
    sum = {1'b0, acc} + (STORE_W + 1)'(w);
    return sum[STORE_W] ? STORE_MAX : sum[STORE_W-1:0];
  endfunction

endpackage

>>> hdl/kwch_bin_ram.sv
// Histogram bin memory: one write port, one registered read port.
module kwch_bin_ram #(
  parameter int BIN_COUNT = kwch_pkg::BIN_COUNT_DEFAULT,
  parameter int IDX_W     = $clog2(BIN_COUNT)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [kwch_pkg::STORE_W-1:0] wdata,
  input  logic                        re,
  input  logic [IDX_W-1:0]            raddr,
  output logic [kwch_pkg::STORE_W-1:0] rdata
);

  logic [kwch_pkg::STORE_W-1:0] mem [BIN_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/kwch_kernel.sv
// Kernel stage: registered squares of half sizes and offsets, radius test.
module kwch_kernel (
  input  logic                                clk,
  input  logic                                load,
  input  logic [kwch_pkg::HALF_W-1:0]         half_width,
  input  logic [kwch_pkg::HALF_W-1:0]         half_height,
  input  logic signed [kwch_pkg::OFFSET_W-1:0] offset_x,
  input  logic signed [kwch_pkg::OFFSET_W-1:0] offset_y,
  output kwch_pkg::kern_res_t                 res
);

  logic [kwch_pkg::HALF_W-1:0]   hx, hy, ax, ay;
  logic [kwch_pkg::SQ_W-1:0]     hx_sq, hy_sq, dx_sq, dy_sq;
  logic [kwch_pkg::RADIUS_W-1:0] r2, d2;

  // Clamp half sizes; take offset magnitudes (minus 64 maps to 64)
  always_comb begin
    hx = (9'(half_width) > 9'(kwch_pkg::MAX_HALF_SIZE))
       ? kwch_pkg::HALF_W'(kwch_pkg::MAX_HALF_SIZE) : half_width;
    hy = (9'(half_height) > 9'(kwch_pkg::MAX_HALF_SIZE))
       ? kwch_pkg::HALF_W'(kwch_pkg::MAX_HALF_SIZE) : half_height;
    ax = offset_x[kwch_pkg::OFFSET_W-1] ? kwch_pkg::HALF_W'(-offset_x)
                                        : kwch_pkg::HALF_W'(offset_x);
    ay = offset_y[kwch_pkg::OFFSET_W-1] ? kwch_pkg::HALF_W'(-offset_y)
                                        : kwch_pkg::HALF_W'(offset_y);
  end

  // Register the four squares
  always_ff @(posedge clk) begin
    if (load) begin
      hx_sq <= kwch_pkg::SQ_W'(hx) * kwch_pkg::SQ_W'(hx);
      hy_sq <= kwch_pkg::SQ_W'(hy) * kwch_pkg::SQ_W'(hy);
      dx_sq <= kwch_pkg::SQ_W'(ax) * kwch_pkg::SQ_W'(ax);
      dy_sq <= kwch_pkg::SQ_W'(ay) * kwch_pkg::SQ_W'(ay);
    end
  end

  // Sum, compare, and form the weight numerator
  always_comb begin
    r2            = kwch_pkg::RADIUS_W'(hx_sq) + kwch_pkg::RADIUS_W'(hy_sq);
    d2            = kwch_pkg::RADIUS_W'(dx_sq) + kwch_pkg::RADIUS_W'(dy_sq);
    res.in_radius = d2 < r2;
    res.numer     = r2 - d2;
    res.radius_sq = r2;
  end

endmodule

>>> hdl/kwch_divider.sv
// Restoring divider, one quotient bit per cycle, for numerator below divisor.
module kwch_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [kwch_pkg::STORE_W-1:0]        numer,
  input  logic [kwch_pkg::STORE_W-1:0]        denom,
  output logic                                done,
  output logic [kwch_pkg::QUOT_BITS-1:0]      quotient
);

  logic                          running;
  logic [kwch_pkg::QCNT_W-1:0]   count;
  logic [kwch_pkg::STORE_W-1:0]  rem, den, rem_next;
  logic [kwch_pkg::STORE_W:0]    shifted, diff;
  logic                          ge;

  // One trial subtraction of the doubled remainder
  always_comb begin
    shifted  = {rem, 1'b0};
    diff     = shifted - {1'b0, den};
    ge       = shifted >= {1'b0, den};
    rem_next = ge ? diff[kwch_pkg::STORE_W-1:0] : shifted[kwch_pkg::STORE_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && count == kwch_pkg::QCNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Remainder, divisor and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= numer;
      den      <= denom;
      quotient <= '0;
      count    <= kwch_pkg::QCNT_W'(kwch_pkg::QUOT_BITS);
    end else if (running) begin
      rem      <= rem_next;
      quotient <= {quotient[kwch_pkg::QUOT_BITS-2:0], ge};
      count    <= count - kwch_pkg::QCNT_W'(1);
    end
  end

endmodule

>>> hdl/kernel_weighted_color_histogram.sv
// Top level: command control, configuration registers and result registers.
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+-------------------------------------
//   command   | start, busy                   | cmd, red, green, blue, offset_x,
//             |                               | offset_y, bin_select
//   result    | result_valid (one-cycle pulse)| kernel_weight, bin_fraction, empty_flag
//   config    | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// A command transfers when start is high and busy is low; exactly one result follows.
// Accumulate uses the kernel stage and the shared bit-serial divider (16 steps), with no
// division outside the radius; read divides the bin by the total unless the total is zero
// or the bin reaches the total; no-op replies from idle; clear zeroes one entry per cycle.
// After reset the memory clear runs with busy high; configuration writes are taken at
// any time. The receiver cannot stall the result.
module kernel_weighted_color_histogram #(
  parameter int BIN_COUNT = kwch_pkg::BIN_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           cmd,
  input  logic [kwch_pkg::CHAN_W-1:0]          red,
  input  logic [kwch_pkg::CHAN_W-1:0]          green,
  input  logic [kwch_pkg::CHAN_W-1:0]          blue,
  input  logic signed [kwch_pkg::OFFSET_W-1:0] offset_x,
  input  logic signed [kwch_pkg::OFFSET_W-1:0] offset_y,
  input  logic [kwch_pkg::SELECT_W-1:0]        bin_select,
  output logic                                 result_valid,
  output logic [kwch_pkg::WEIGHT_W-1:0]        kernel_weight,
  output logic [kwch_pkg::FRACTION_W-1:0]      bin_fraction,
  output logic                                 empty_flag,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [kwch_pkg::HALF_W-1:0]          cfg_data
);

  // BIN_COUNT must be a power of two, which the block does not enforce; indexes wrap by masking
  localparam int IDX_W = $clog2(BIN_COUNT);

  kwch_pkg::state_t state, state_next;

  logic [IDX_W-1:0]                  sweep_cnt, sweep_cnt_next;
  logic                              sweep_reply, sweep_reply_next;
  logic [IDX_W-1:0]                  acc_idx, acc_idx_next;
  logic [kwch_pkg::WEIGHT_W-1:0]     weight, weight_next;
  logic [kwch_pkg::STORE_W-1:0]      total, total_next;
  logic [kwch_pkg::HALF_W-1:0]       half_width, half_height;

  logic                              result_valid_next, empty_flag_next;
  logic [kwch_pkg::WEIGHT_W-1:0]     kernel_weight_next;
  logic [kwch_pkg::FRACTION_W-1:0]   bin_fraction_next;

  logic                              ram_we, ram_re;
  logic [IDX_W-1:0]                  ram_waddr, ram_raddr;
  logic [kwch_pkg::STORE_W-1:0]      ram_wdata, ram_rdata;

  logic                              div_start, div_done;
  logic [kwch_pkg::STORE_W-1:0]      div_numer, div_denom;
  logic [kwch_pkg::QUOT_BITS-1:0]    div_quot;

  logic                              kern_load;
  kwch_pkg::kern_res_t               kern;

  logic                              accept;
  logic [IDX_W-1:0]                  color_idx, select_idx;

  assign busy      = (state != kwch_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Coarse color index: top three bits of each channel
  assign color_idx  = IDX_W'({red[7:5], green[7:5], blue[7:5]});
  assign select_idx = IDX_W'(bin_select);

  kwch_bin_ram #(
    .BIN_COUNT (BIN_COUNT),
    .IDX_W     (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kwch_kernel u_kernel (
    .clk         (clk),
    .load        (kern_load),
    .half_width  (half_width),
    .half_height (half_height),
    .offset_x    (offset_x),
    .offset_y    (offset_y),
    .res         (kern)
  );

  kwch_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (div_denom),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= kwch_pkg::HALF_W'(kwch_pkg::RESET_HALF);
      half_height <= kwch_pkg::HALF_W'(kwch_pkg::RESET_HALF);
    end else if (cfg_valid && cfg_ready) begin
      unique case (kwch_pkg::reg_index_t'(cfg_index))
        kwch_pkg::REG_HALF_WIDTH:  half_width  <= cfg_data;
        kwch_pkg::REG_HALF_HEIGHT: half_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kwch_pkg::ST_SWEEP;
      sweep_cnt    <= '0;
      sweep_reply  <= 1'b0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      sweep_cnt    <= sweep_cnt_next;
      sweep_reply  <= sweep_reply_next;
      total        <= total_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_idx       <= acc_idx_next;
    weight        <= weight_next;
    kernel_weight <= kernel_weight_next;
    bin_fraction  <= bin_fraction_next;
    empty_flag    <= empty_flag_next;
  end

  // Next state, memory and divider control, result values
  always_comb begin
    state_next         = state;
    sweep_cnt_next     = sweep_cnt;
    sweep_reply_next   = sweep_reply;
    acc_idx_next       = acc_idx;
    weight_next        = weight;
    total_next         = total;
    result_valid_next  = 1'b0;
    kernel_weight_next = kernel_weight;
    bin_fraction_next  = bin_fraction;
    empty_flag_next    = empty_flag;
    ram_we             = 1'b0;
    ram_waddr          = acc_idx;
    ram_wdata          = kwch_pkg::sat_add(ram_rdata, weight);
    ram_re             = 1'b0;
    ram_raddr          = color_idx;
    div_start          = 1'b0;
    div_numer          = kwch_pkg::STORE_W'(kern.numer);
    div_denom          = kwch_pkg::STORE_W'(kern.radius_sq);
    kern_load          = 1'b0;

    unique case (state)
      // Zero the store one entry a cycle
      kwch_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt;
        ram_wdata = '0;
        sweep_cnt_next = sweep_cnt + IDX_W'(1);
        if (sweep_cnt == IDX_W'(BIN_COUNT - 1)) begin
          total_next = '0;
          state_next = kwch_pkg::ST_IDLE;
          if (sweep_reply) begin
            result_valid_next  = 1'b1;
            kernel_weight_next = '0;
            bin_fraction_next  = '0;
            empty_flag_next    = 1'b0;
          end
        end
      end

      // Take a command
      kwch_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kwch_pkg::cmd_t'(cmd))
            kwch_pkg::CMD_CLEAR: begin
              sweep_cnt_next   = '0;
              sweep_reply_next = 1'b1;
              state_next       = kwch_pkg::ST_SWEEP;
            end
            kwch_pkg::CMD_ACCUM: begin
              ram_re       = 1'b1;
              ram_raddr    = color_idx;
              acc_idx_next = color_idx;
              kern_load    = 1'b1;
              state_next   = kwch_pkg::ST_ACC_KERNEL;
            end
            kwch_pkg::CMD_READ: begin
              ram_re     = 1'b1;
              ram_raddr  = select_idx;
              state_next = kwch_pkg::ST_READ_FETCH;
            end
            kwch_pkg::CMD_NOP: begin
              result_valid_next  = 1'b1;
              kernel_weight_next = '0;
              bin_fraction_next  = '0;
              empty_flag_next    = 1'b0;
            end
          endcase
        end
      end

      // Start the weight division, or drop to zero weight outside the radius
      kwch_pkg::ST_ACC_KERNEL: begin
        if (kern.in_radius) begin
          div_start  = 1'b1;
          state_next = kwch_pkg::ST_ACC_DIV;
        end else begin
          weight_next = '0;
          state_next  = kwch_pkg::ST_ACC_WRITE;
        end
      end

      kwch_pkg::ST_ACC_DIV: begin
        if (div_done) begin
          weight_next = div_quot;
          state_next  = kwch_pkg::ST_ACC_WRITE;
        end
      end

      // Write back the bin, advance the total, report the weight
      kwch_pkg::ST_ACC_WRITE: begin
        ram_we             = 1'b1;
        total_next         = kwch_pkg::sat_add(total, weight);
        result_valid_next  = 1'b1;
        kernel_weight_next = weight;
        bin_fraction_next  = '0;
        empty_flag_next    = 1'b0;
        state_next         = kwch_pkg::ST_IDLE;
      end

      // Bin is ready: handle empty total and full share, else divide
      kwch_pkg::ST_READ_FETCH: begin
        div_numer = ram_rdata;
        div_denom = total;
        if (total == '0) begin
          result_valid_next  = 1'b1;
          kernel_weight_next = '0;
          bin_fraction_next  = '0;
          empty_flag_next    = 1'b1;
          state_next         = kwch_pkg::ST_IDLE;
        end else if (ram_rdata >= total) begin
          result_valid_next  = 1'b1;
          kernel_weight_next = '0;
          bin_fraction_next  = kwch_pkg::FRACTION_ONE;
          empty_flag_next    = 1'b0;
          state_next         = kwch_pkg::ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = kwch_pkg::ST_READ_DIV;
        end
      end

      kwch_pkg::ST_READ_DIV: begin
        if (div_done) begin
          result_valid_next  = 1'b1;
          kernel_weight_next = '0;
          bin_fraction_next  = kwch_pkg::FRACTION_W'(div_quot);
          empty_flag_next    = 1'b0;
          state_next         = kwch_pkg::ST_IDLE;
        end
      end

      default: state_next = kwch_pkg::ST_IDLE;
    endcase
  end

endmodule
